@@ rtl/sesf_pkg.sv @@
// Shared constants and types for the scanline edge-span fill block.
// Used by the divider, the edge table and the top level; no dependencies.
package sesf_pkg;

  localparam int COORD_W     = 16;
  localparam int ACT_W       = 2;
  localparam int ROW_IN_W    = 10;
  localparam int SPAN_W      = 10;
  localparam int SLOPE_FRAC  = 16;
  localparam int ACC_W       = 48;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  localparam int DIV_DVD_W = 32;
  localparam int DIV_DSR_W = 16;
  localparam int DIV_CNT_W = 5;

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] TBL_CLEAR = 2'd0;
  localparam logic [1:0] TBL_MERGE = 2'd1;
  localparam logic [1:0] TBL_READ  = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [1:0] op;
  } tbl_ctl_t;

endpackage

@@ rtl/sesf_div.sv @@
// Restoring divider, one quotient bit per cycle, for the edge slope.
// Depends on sesf_pkg for operand widths.
module sesf_div
  import sesf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_DSR_W-1:0] divisor,
  output logic                 busy,
  output logic                 done,
  output logic [DIV_DVD_W-1:0] quotient
);

  logic [DIV_DSR_W-1:0] rem;
  logic [DIV_DVD_W-1:0] quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DSR_W:0]   rem_sh;
  logic [DIV_DSR_W:0]   diff;
  logic                 ge;

  assign rem_sh   = {rem, quo[DIV_DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign diff     = rem_sh - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DSR_W-1:0] : rem_sh[DIV_DSR_W-1:0];
      quo <= {quo[DIV_DVD_W-2:0], ge};
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held longer than one cycle");

endmodule

@@ rtl/sesf_table.sv @@
// Left/right edge table: one synchronous memory, read-merge-write pipeline.
// Depends on sesf_pkg for the request struct and op codes.
module sesf_table
  import sesf_pkg::*;
#(
  parameter int ROWS = 1024,
  parameter int COLS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tbl_ctl_t                 ctl,
  input  logic [$clog2(ROWS)-1:0]  row,
  input  logic [$clog2(COLS)-1:0]  col,
  output logic [$clog2(COLS)-1:0]  rd_left,
  output logic [$clog2(COLS)-1:0]  rd_right
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam logic [CW-1:0] CMAX = CW'(COLS - 1);

  logic [2*CW-1:0] mem [ROWS];
  logic [2*CW-1:0] rd_word;
  logic            p_valid;
  logic [RW-1:0]   p_row;
  logic [CW-1:0]   p_col;
  logic [CW-1:0]   mrg_left;
  logic [CW-1:0]   mrg_right;
  logic            wr_en;
  logic [RW-1:0]   wr_row;
  logic [2*CW-1:0] wr_word;

  assign rd_left  = rd_word[CW-1:0];
  assign rd_right = rd_word[2*CW-1:CW];

  // Merge: left keeps the minimum, right the maximum column.
  assign mrg_left  = (p_col < rd_left)  ? p_col : rd_left;
  assign mrg_right = (p_col > rd_right) ? p_col : rd_right;

  assign wr_en   = p_valid || (ctl.valid && ctl.op == TBL_CLEAR);
  assign wr_row  = p_valid ? p_row : row;
  assign wr_word = p_valid ? {mrg_right, mrg_left} : {{CW{1'b0}}, CMAX};

  always_ff @(posedge clk) begin
    if (ctl.valid && ctl.op inside {TBL_MERGE, TBL_READ}) begin
      rd_word <= mem[row];
    end
    if (wr_en) begin
      mem[wr_row] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= ctl.valid && ctl.op == TBL_MERGE;
    end
    p_row <= row;
    p_col <= col;
  end

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> !(ctl.valid && ctl.op == TBL_CLEAR))
    else $error("clear collides with merge write");
  a_no_raw: assert property (@(posedge clk) disable iff (rst)
    (p_valid && ctl.valid && (ctl.op == TBL_MERGE || ctl.op == TBL_READ))
      |-> row != p_row)
    else $error("read of a row with a pending merge write");
  a_merge_write: assert property (@(posedge clk) disable iff (rst)
    (ctl.valid && ctl.op == TBL_MERGE) |=> p_valid)
    else $error("merge request lost its write-back");

endmodule

@@ rtl/scanline_edge_span_fill_core.sv @@
// Scanline edge-span fill: keeps per-row left and right edge columns in one
// table memory. Each input transfer carries an action in tuser. Clear resets
// every row to an empty span. Add edge orders the endpoints by y and runs a
// setup step; an edge that starts past the last row ends there. Otherwise,
// unless the edge is horizontal, it then runs the bit-serial slope divider
// for its 32 quotient bits and hands the quotient over. It then walks one
// row per cycle through the table's read-merge-write pipeline (rows covered
// at most ROWS). Read span runs one memory read, capture, and the result
// load. Every action yields exactly one result transfer; only a read returns
// nonzero data. After reset the block runs a clearing pass over every row
// before it accepts the first transfer. An output register holds the result,
// so the next item is taken while the previous result still waits on the
// master side.
module scanline_edge_span_fill_core
  import sesf_pkg::*;
#(
  parameter int ROWS      = 1024,
  parameter int COLS      = 1024,
  parameter int FRAC_BITS = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // x_start [15:0], y_start [31:16], x_end [47:32], y_end [63:48],
  // row_index [73:64], zero pad [79:74]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // action [1:0]
  input  logic [ACT_W-1:0]       s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // span_left [9:0], span_right [19:10], span_nonempty [20], zero pad [23:21]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int XSH   = SLOPE_FRAC - FRAC_BITS;
  localparam int XI_W  = ACC_W - 1 - SLOPE_FRAC;
  localparam logic [COORD_W-1:0] ROW_MAX = COORD_W'(ROWS - 1);
  localparam logic [CW-1:0]      CMAX    = CW'(COLS - 1);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;

  // Input field views.
  logic [COORD_W-1:0]  in_x_start, in_y_start, in_x_end, in_y_end;
  logic [ROW_IN_W-1:0] in_row;
  logic                accept;
  logic                row_ok;

  assign in_x_start = s_tdata[15:0];
  assign in_y_start = s_tdata[31:16];
  assign in_x_end   = s_tdata[47:32];
  assign in_y_end   = s_tdata[63:48];
  assign in_row     = s_tdata[73:64];
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign row_ok     = int'(in_row) < ROWS;

  // Ordered endpoints: lower y first, first endpoint wins a tie.
  logic [COORD_W-1:0] xl, yl, xh, yh;

  // Edge setup, evaluated from the ordered endpoints.
  logic [COORD_W-1:0] dy, mag, row_first, row_top, row_stop;
  logic               dx_neg, walk_none;

  assign dy        = yh - yl;
  assign dx_neg    = xh < xl;
  assign mag       = dx_neg ? (xl - xh) : (xh - xl);
  assign row_first = yl >> FRAC_BITS;
  assign row_top   = yh >> FRAC_BITS;
  assign row_stop  = (row_top > ROW_MAX) ? ROW_MAX : row_top;
  assign walk_none = row_first > row_stop;

  // Walk state.
  logic                    neg_q;
  logic [DIV_DVD_W-1:0]    slope_mag;
  logic signed [ACC_W-1:0] x_acc;
  logic signed [ACC_W-1:0] slope_ext;
  logic [RW-1:0]           row_cur, row_last;
  logic [XI_W-1:0]         x_int;
  logic [CW-1:0]           col;

  assign slope_ext = signed'(ACC_W'(slope_mag));
  assign x_int     = x_acc[ACC_W-2:SLOPE_FRAC];

  // Column is floor(x), clamped to the table's width.
  always_comb begin
    if (x_acc[ACC_W-1]) begin
      col = '0;
    end else if (x_int > XI_W'(COLS - 1)) begin
      col = CMAX;
    end else begin
      col = CW'(x_int);
    end
  end

  // Slope divider: (|dx| << 16) / dy.
  logic                 div_start, div_busy, div_done;
  logic [DIV_DVD_W-1:0] div_quo;

  assign div_start = (state == S_SETUP) && !walk_none && (dy != '0);

  sesf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag, {SLOPE_FRAC{1'b0}}}),
    .divisor  (dy),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Table requests.
  tbl_ctl_t      tbl_ctl;
  logic [RW-1:0] tbl_row;
  logic [CW-1:0] tbl_col;
  logic [CW-1:0] tbl_left, tbl_right;

  always_comb begin
    tbl_ctl = '0;
    tbl_row = row_cur;
    tbl_col = col;
    case (state)
      S_INIT, S_CLEAR: begin
        tbl_ctl.valid = 1'b1;
        tbl_ctl.op    = TBL_CLEAR;
      end
      S_WALK: begin
        tbl_ctl.valid = 1'b1;
        tbl_ctl.op    = TBL_MERGE;
      end
      S_IDLE: begin
        if (accept && s_tuser == ACT_READ && row_ok) begin
          tbl_ctl.valid = 1'b1;
          tbl_ctl.op    = TBL_READ;
          tbl_row       = RW'(in_row);
        end
      end
      default: begin
        tbl_ctl = '0;
      end
    endcase
  end

  sesf_table #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tbl_ctl),
    .row      (tbl_row),
    .col      (tbl_col),
    .rd_left  (tbl_left),
    .rd_right (tbl_right)
  );

  // Result staging.
  logic [SPAN_W-1:0] res_left, res_right;
  logic              res_nonempty;
  logic              out_load;

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      row_cur <= '0;
    end else begin
      case (state)
        S_INIT, S_CLEAR: begin
          // Sweep every row back to an empty span.
          if (row_cur == RW'(ROWS - 1)) begin
            state <= (state == S_INIT) ? S_IDLE : S_DONE;
          end else begin
            row_cur <= row_cur + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (s_tuser)
              ACT_CLEAR: begin
                row_cur <= '0;
                state   <= S_CLEAR;
              end
              ACT_EDGE: state <= S_SETUP;
              ACT_READ: state <= row_ok ? S_READ : S_DONE;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_SETUP: begin
          row_cur <= RW'(row_first);
          if (walk_none) begin
            state <= S_DONE;
          end else if (dy != '0) begin
            state <= S_DIV;
          end else begin
            state <= S_WALK;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          // One row per cycle; the merge write lands in the next cycle.
          if (row_cur == row_last) begin
            state <= S_DONE;
          end else begin
            row_cur <= row_cur + 1'b1;
          end
        end
        S_READ:  state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_y_end < in_y_start) begin
        xl <= in_x_end;
        yl <= in_y_end;
        xh <= in_x_start;
        yh <= in_y_start;
      end else begin
        xl <= in_x_start;
        yl <= in_y_start;
        xh <= in_x_end;
        yh <= in_y_end;
      end
      res_left     <= '0;
      res_right    <= '0;
      res_nonempty <= 1'b0;
    end
    if (state == S_SETUP) begin
      neg_q    <= dx_neg;
      row_last <= RW'(row_stop);
      x_acc    <= signed'(ACC_W'({xl, {XSH{1'b0}}}));
      // Horizontal edge steps by dx itself.
      slope_mag <= DIV_DVD_W'({mag, {XSH{1'b0}}});
    end
    if (state == S_DIV && div_done) begin
      slope_mag <= div_quo;
    end
    if (state == S_WALK) begin
      x_acc <= neg_q ? (x_acc - slope_ext) : (x_acc + slope_ext);
    end
    if (state == S_READ) begin
      res_left     <= SPAN_W'(tbl_left);
      res_right    <= SPAN_W'(tbl_right);
      res_nonempty <= tbl_left < tbl_right;
    end
  end

  // Output register: hold until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'({res_nonempty, res_right, res_left});
    end
  end

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (row_cur <= row_last))
    else $error("edge walk passed its last row");
  a_read_path: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == ACT_READ && row_ok) |=> (state == S_READ))
    else $error("span read did not enter read state");
  a_div_active: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

endmodule

@@ tb/tb_scanline_edge_span_fill_core.sv @@
// Self-checking bench for scanline_edge_span_fill_core: predicts every row span
// with its own edge tables and checks each result transfer against it.
// Depends on sesf_pkg and the core RTL only.
module tb_scanline_edge_span_fill_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sesf_pkg::*;

  localparam int ROW_COUNT    = 1024;
  localparam int COL_COUNT    = 1024;
  localparam int FRAC         = 6;
  localparam int RANDOM_ITEMS = 580;
  localparam int MAX_GAP      = 18;
  // action code the block ignores; it still answers with an all-zero result
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [SPAN_W-1:0] left;
    logic [SPAN_W-1:0] right;
    logic              nonempty;
  } span_t;

  // Edge-table predictor plus the queue of spans still owed by the block.
  class span_scoreboard;
    logic [SPAN_W-1:0] left_col [ROW_COUNT];
    logic [SPAN_W-1:0] right_col [ROW_COUNT];
    span_t             owed_spans [$];
    int                mismatches;

    function new();
      mismatches = 0;
      clear_spans();
    endfunction

    function void clear_spans();
      foreach (left_col[r]) begin
        left_col[r]  = SPAN_W'(COL_COUNT - 1);
        right_col[r] = '0;
      end
    endfunction

    // Truncate x (16 fraction bits) to a column and clamp it to the screen.
    function int column_at(longint x);
      longint c;
      if (x < 0) return 0;
      c = x >>> SLOPE_FRAC;
      if (c > COL_COUNT - 1) return COL_COUNT - 1;
      return int'(c);
    endfunction

    // Walk one edge from the floor of its lower y to the floor of its upper y.
    function void fold_edge(logic [COORD_W-1:0] xa, logic [COORD_W-1:0] ya,
                            logic [COORD_W-1:0] xb, logic [COORD_W-1:0] yb);
      logic [COORD_W-1:0] xl, yl, xh, yh;
      longint dx, dy, mag, slope, x;
      int row, top_row, col;
      if (yb < ya) begin
        xl = xb; yl = yb; xh = xa; yh = ya;
      end else begin
        xl = xa; yl = ya; xh = xb; yh = yb;
      end
      dy  = longint'(yh) - longint'(yl);
      dx  = longint'(xh) - longint'(xl);
      mag = (dx < 0) ? -dx : dx;
      // slope is per raw y unit even though x advances once per row
      if (dy != 0) slope = (mag << SLOPE_FRAC) / dy;
      else slope = mag << (SLOPE_FRAC - FRAC);
      if (dx < 0) slope = -slope;
      x       = longint'(xl) << (SLOPE_FRAC - FRAC);
      row     = int'(yl >> FRAC);
      top_row = int'(yh >> FRAC);
      if (top_row > ROW_COUNT - 1) top_row = ROW_COUNT - 1;
      for (; row <= top_row; row++) begin
        col = column_at(x);
        if (col < left_col[row]) left_col[row] = SPAN_W'(col);
        if (col > right_col[row]) right_col[row] = SPAN_W'(col);
        x += slope;
      end
    endfunction

    // Apply one accepted input and queue the span it must produce.
    function void note_action(logic [ACT_W-1:0] act,
                              logic [COORD_W-1:0] xs, logic [COORD_W-1:0] ys,
                              logic [COORD_W-1:0] xe, logic [COORD_W-1:0] ye,
                              logic [ROW_IN_W-1:0] row);
      span_t s;
      s.left = '0;
      s.right = '0;
      s.nonempty = 1'b0;
      case (act)
        ACT_CLEAR: clear_spans();
        ACT_EDGE:  fold_edge(xs, ys, xe, ye);
        ACT_READ: begin
          if (row < ROW_COUNT) begin
            s.left     = left_col[row];
            s.right    = right_col[row];
            s.nonempty = (left_col[row] < right_col[row]);
          end
        end
        default: ;
      endcase
      owed_spans.push_back(s);
    endfunction

    function void check_span(logic [OUT_TDATA_W-1:0] tdata);
      logic [SPAN_W-1:0] got_left, got_right;
      logic              got_nonempty;
      span_t             want;
      got_left     = tdata[SPAN_W-1:0];
      got_right    = tdata[2*SPAN_W-1:SPAN_W];
      got_nonempty = tdata[2*SPAN_W];
      if (owed_spans.size() == 0) begin
        $display("%0t: unexpected result transfer, data %h", $time, tdata);
        mismatches++;
        return;
      end
      want = owed_spans.pop_front();
      if (got_left !== want.left) begin
        $display("%0t: span_left expected %0d, got %0d", $time, want.left, got_left);
        mismatches++;
      end
      if (got_right !== want.right) begin
        $display("%0t: span_right expected %0d, got %0d", $time, want.right, got_right);
        mismatches++;
      end
      if (got_nonempty !== want.nonempty) begin
        $display("%0t: span_nonempty expected %0d, got %0d", $time, want.nonempty,
                 got_nonempty);
        mismatches++;
      end
      if (tdata[OUT_TDATA_W-1:2*SPAN_W+1] !== '0) begin
        $display("%0t: result pad expected 0, got %h", $time,
                 tdata[OUT_TDATA_W-1:2*SPAN_W+1]);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return owed_spans.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [ACT_W-1:0]       s_tuser = ACT_CLEAR;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // when set, the matching side runs back to back with no idle cycles
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;

  span_scoreboard board;

  scanline_edge_span_fill_core #(
    .ROWS(ROW_COUNT),
    .COLS(COL_COUNT),
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Offer one input transfer after a random idle gap; hold it until accepted.
  // s_tvalid stays high between back-to-back items so it is never dropped and
  // raised in the same step.
  task automatic send_action(input logic [ACT_W-1:0] act,
                             input logic [COORD_W-1:0] xs, input logic [COORD_W-1:0] ys,
                             input logic [COORD_W-1:0] xe, input logic [COORD_W-1:0] ye,
                             input logic [ROW_IN_W-1:0] row);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    // pad [79:74], row_index, y_end, x_end, y_start, x_start from the top down
    s_tdata  <= {6'b0, row, ye, xe, ys, xs};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    board.note_action(act, xs, ys, xe, ye, row);
  endtask

  // Result side: stall a random number of cycles, then take one transfer and
  // check it. A zero stall keeps tready high across consecutive results.
  initial begin
    int stall;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_steady = ~recv_steady;
      stall = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      board.check_span(m_tdata);
    end
  end

  // Watchdog: the slowest legal run is well under a quarter of this.
  initial begin
    #30_000_000;
    $display("tb_scanline_edge_span_fill_core: FAIL");
    $finish;
  end

  initial begin
    logic [COORD_W-1:0]  vx [8];
    logic [COORD_W-1:0]  vy [8];
    logic [ROW_IN_W-1:0] row;
    int counted, nverts, nreads, ybase, yspan, i;

    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // Row zero straight after reset: empty span.
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd0);
    // Ignored action with random payload: no state change, zero result.
    send_action(ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                10'd20);
    // Horizontal edge: single row 20 at floor(x_start).
    send_action(ACT_EDGE, 16'h1234, 16'h0500, 16'hFFFF, 16'h0500, 10'd0);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd20);
    // Endpoints given top first, full x and y range: walks every row.
    send_action(ACT_EDGE, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 10'd1023);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd0);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd1023);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd20);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd500);
    // Overshoot past the right side: steep dx over one raw y unit.
    send_action(ACT_EDGE, 16'h0000, 16'h003F, 16'hFFFF, 16'h0040, 10'd0);
    // Overshoot below column zero.
    send_action(ACT_EDGE, 16'hFFFF, 16'h007F, 16'h0000, 16'h0080, 10'd0);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd1);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd2);
    // Clear with junk payload, then confirm rows are empty again.
    send_action(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd1023);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd1);
    // All-zero edge: row 0, column 0, still an empty span.
    send_action(ACT_EDGE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd0);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd0);
    // Edge confined to the last row.
    send_action(ACT_EDGE, 16'h0040, 16'hFFC0, 16'h0080, 16'hFFFF, 10'd0);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd1023);
    // Ignored action with all ones must not touch the last row.
    send_action(ACT_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
    send_action(ACT_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd1023);

    // ---- random part: closed polygons over a band of rows, then reads ----
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      send_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        send_action(ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 10'($urandom));
        counted++;
      end
      // keep most bands short so edges stay cheap; a few cover the screen
      yspan  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2047);
      ybase  = $urandom_range(0, 65535 - yspan);
      nverts = $urandom_range(2, 6);
      for (i = 0; i < nverts; i++) begin
        vx[i] = 16'($urandom_range(0, 65535));
        if (i > 0 && $urandom_range(0, 7) == 0) vy[i] = vy[i-1];
        else vy[i] = 16'(ybase + $urandom_range(0, yspan));
      end
      for (i = 0; i < nverts; i++) begin
        send_action(ACT_EDGE, vx[i], vy[i], vx[(i+1)%nverts], vy[(i+1)%nverts],
                    10'($urandom));
        counted++;
      end
      nreads = $urandom_range(2, 8);
      for (i = 0; i < nreads; i++) begin
        if ($urandom_range(0, 7) == 0) row = 10'($urandom);
        else row = 10'((ybase + $urandom_range(0, yspan)) >> FRAC);
        send_action(ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), row);
        counted++;
      end
      // noise: stray actions between polygons
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: send_action(ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 10'($urandom));
          1: begin
            send_action(ACT_EDGE, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 10'($urandom));
            counted++;
          end
          default: begin
            send_action(ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 10'($urandom));
            counted++;
          end
        endcase
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every owed span, then allow a read's latency for strays.
    while (board.outstanding() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("tb_scanline_edge_span_fill_core: PASS");
    end else begin
      $display("tb_scanline_edge_span_fill_core: FAIL");
    end
    $finish;
  end

endmodule
